/* hw/rtl/knnmv_pkg.sv */
// Shared widths, register indexes, reset values, label tables and the sample type.
package knnmv_pkg;

  // Fixed field widths of the streaming and configuration ports.
  localparam int DistW    = 32;
  localparam int LabelW   = 4;
  localparam int IdW      = 5;
  localparam int KeptW    = 4;
  localparam int MaskW    = 10;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 40;
  localparam int OutDataW = 16;

  // Filter modes.
  localparam logic [ModeW-1:0] ModeBasic     = 2'd0;
  localparam logic [ModeW-1:0] ModeBuilding  = 2'd1;
  localparam logic [ModeW-1:0] ModeSculpture = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFilterMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDistLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAvailMask  = 2'd2;

  // Register reset values; the limit is 100.0 in Q16.16.
  localparam logic [DistW-1:0] DistLimitReset = 32'd6553600;
  localparam logic [MaskW-1:0] AvailMaskReset = 10'h3FF;

  // Prediction code for "not enough neighbors" (-1 in five bits).
  localparam logic [IdW-1:0] PredictedNone = 5'h1F;

  // One filtered sample on its way into the neighbor list.
  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [LabelW-1:0] id;
    logic              keep;
    logic              last;
  } sample_t;

  // Maps a raw label to a class id for the given mode; zero means dropped.
  function automatic logic [LabelW-1:0] map_label(logic [ModeW-1:0] mode,
                                                  logic [LabelW-1:0] label);
    logic [LabelW-1:0] id;
    id = '0;
    case (mode)
      ModeBasic: id = label;
      ModeBuilding: begin
        case (label)
          4'd1:    id = 4'd9;
          4'd2:    id = 4'd4;
          4'd3:    id = 4'd8;
          4'd4:    id = 4'd6;
          4'd5:    id = 4'd1;
          default: id = '0;
        endcase
      end
      ModeSculpture: begin
        case (label)
          4'd1:    id = 4'd7;
          4'd2:    id = 4'd10;
          4'd3:    id = 4'd3;
          4'd4:    id = 4'd5;
          default: id = '0;
        endcase
      end
      default: id = '0;
    endcase
    return id;
  endfunction

endpackage

/* hw/rtl/knnmv_ingress.sv */
// Input stage: label mapping, distance and availability filter, sample register.
module knnmv_ingress import knnmv_pkg::*; #(
  parameter int CLASS_COUNT = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DistW-1:0]  in_dist_i,
  input  logic [LabelW-1:0] in_label_i,
  input  logic              in_last_i,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [DistW-1:0]  limit_i,
  input  logic [MaskW-1:0]  mask_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sample_t           sample_o
);

  localparam logic [LabelW-1:0] ClassMax = LabelW'(CLASS_COUNT);

  logic              valid_q;
  sample_t           sample_q, sample_d;
  logic [LabelW-1:0] id;
  logic [15:0]       mask_wide;
  logic              id_ok;

  // Map the label and decide whether the sample enters the list.
  always_comb begin
    id        = map_label(mode_i, in_label_i);
    mask_wide = {{(16 - MaskW){1'b0}}, mask_i};
    id_ok     = (id != '0) && (id <= ClassMax);
    sample_d.distance = in_dist_i;
    sample_d.id       = id;
    sample_d.last     = in_last_i;
    if (mode_i == ModeBasic) begin
      sample_d.keep = id_ok;
    end else begin
      sample_d.keep = id_ok && (in_dist_i < limit_i) && mask_wide[id - 4'd1];
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Valid flag of the sample register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Sample payload.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sample_o    = sample_q;

endmodule

/* hw/rtl/knnmv_list.sv */
// Sorted list of the nearest samples with parallel compare and insert.
module knnmv_list import knnmv_pkg::*; #(
  parameter int NEIGHBOURS = 7,
  localparam int CntW = $clog2(NEIGHBOURS + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sample_t           sample_i,
  output logic [LabelW-1:0] labels_o [NEIGHBOURS],
  output logic [CntW-1:0]   count_o
);

  localparam logic [CntW-1:0] CountMax = CntW'(NEIGHBOURS + 1);

  logic [DistW-1:0]  dist_q  [NEIGHBOURS];
  logic [DistW-1:0]  dist_d  [NEIGHBOURS];
  logic [LabelW-1:0] label_q [NEIGHBOURS];
  logic [LabelW-1:0] label_d [NEIGHBOURS];
  logic [CntW-1:0]   count_q, count_d;
  logic [NEIGHBOURS:0] le_ext;

  // Each filled slot at or below the new distance stays; the first slot
  // above it takes the new sample and the rest move down by one.
  always_comb begin
    le_ext[0] = 1'b1;
    for (int i = 0; i < NEIGHBOURS; i++) begin
      le_ext[i+1] = (count_q > CntW'(i)) && (dist_q[i] <= sample_i.distance);
    end
    for (int i = 0; i < NEIGHBOURS; i++) begin
      dist_d[i]  = dist_q[i];
      label_d[i] = label_q[i];
      if (sample_i.keep && !le_ext[i+1]) begin
        if (le_ext[i]) begin
          dist_d[i]  = sample_i.distance;
          label_d[i] = sample_i.id;
        end else if (i > 0) begin
          dist_d[i]  = dist_q[i-1];
          label_d[i] = label_q[i-1];
        end
      end
    end
    count_d = count_q;
    if (sample_i.keep && (count_q < CountMax)) begin
      count_d = count_q + 1'b1;
    end
  end

  // Count of kept samples; a last sample empties the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= sample_i.last ? '0 : count_d;
    end
  end

  // Entries beyond the count only reach a vote that a short list overrides, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (step_i && !sample_i.last) begin
      dist_q  <= dist_d;
      label_q <= label_d;
    end
  end

  assign labels_o = label_d;
  assign count_o  = count_d;

  // The count saturates one above the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountMax)
    else $error("kept count above saturation");

  // A last sample leaves an empty list behind.
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && sample_i.last |=> count_q == '0)
    else $error("list not cleared after last sample");

  // Filled entries stay sorted by distance.
  for (genvar g = 0; g + 1 < NEIGHBOURS; g++) begin : g_sorted
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q > CntW'(g + 1)) |-> (dist_q[g] <= dist_q[g+1]))
      else $error("neighbor list out of order");
  end

endmodule

/* hw/rtl/knnmv_vote.sv */
// Vote pipeline: label snapshot, per-class tallies, tree search, result register.
module knnmv_vote import knnmv_pkg::*; #(
  parameter int NEIGHBOURS  = 7,
  parameter int CLASS_COUNT = 10,
  localparam int CntW = $clog2(NEIGHBOURS + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [LabelW-1:0] labels_i [NEIGHBOURS],
  input  logic [CntW-1:0]   count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IdW-1:0]    predicted_id_o,
  output logic [KeptW-1:0]  kept_count_o
);

  localparam int TallyW = $clog2(NEIGHBOURS + 1);
  localparam int Leaves = 2 ** $clog2(CLASS_COUNT);
  localparam int Nodes  = 2 * Leaves - 1;

  logic a_v, b_v, c_v;
  logic a_ready, b_ready, c_ready;

  logic [LabelW-1:0] a_labels_q [NEIGHBOURS];
  logic [CntW-1:0]   a_count_q;
  logic [TallyW-1:0] b_tally_q [CLASS_COUNT];
  logic [TallyW-1:0] tally_d   [CLASS_COUNT];
  logic              b_short_q;
  logic [KeptW-1:0]  b_kept_q;
  logic [IdW-1:0]    c_pred_q, pred_d;
  logic [KeptW-1:0]  c_kept_q;

  logic [TallyW-1:0] node_votes [Nodes];
  logic [LabelW-1:0] node_id    [Nodes];

  // Each stage moves when it is empty or its successor takes the request.
  assign c_ready    = !c_v || out_ready_i;
  assign b_ready    = !b_v || c_ready;
  assign a_ready    = !a_v || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      if (a_ready) a_v <= in_valid_i;
      if (b_ready) b_v <= a_v;
      if (c_ready) c_v <= b_v;
    end
  end

  // Count votes for every class id.
  always_comb begin
    for (int c = 0; c < CLASS_COUNT; c++) begin
      tally_d[c] = '0;
      for (int i = 0; i < NEIGHBOURS; i++) begin
        if (a_labels_q[i] == LabelW'(c + 1)) begin
          tally_d[c] = tally_d[c] + 1'b1;
        end
      end
    end
  end

  // Maximum search as a binary tree; the lower id wins a tie.
  always_comb begin
    for (int n = 0; n < Nodes; n++) begin
      node_votes[n] = '0;
      node_id[n]    = '0;
    end
    for (int l = 0; l < Leaves; l++) begin
      node_id[Leaves - 1 + l] = LabelW'(l + 1);
      if (l < CLASS_COUNT) begin
        node_votes[Leaves - 1 + l] = b_tally_q[l];
      end
    end
    for (int n = Leaves - 2; n >= 0; n--) begin
      if (node_votes[2*n+1] >= node_votes[2*n+2]) begin
        node_votes[n] = node_votes[2*n+1];
        node_id[n]    = node_id[2*n+1];
      end else begin
        node_votes[n] = node_votes[2*n+2];
        node_id[n]    = node_id[2*n+2];
      end
    end
    if (b_short_q || (node_votes[0] == '0)) begin
      pred_d = PredictedNone;
    end else begin
      pred_d = IdW'(node_id[0]);
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_labels_q <= labels_i;
      a_count_q  <= count_i;
    end
    if (b_ready && a_v) begin
      b_tally_q <= tally_d;
      b_short_q <= a_count_q < CntW'(NEIGHBOURS);
      b_kept_q  <= KeptW'(a_count_q);
    end
    if (c_ready && b_v) begin
      c_pred_q <= pred_d;
      c_kept_q <= b_kept_q;
    end
  end

  assign out_valid_o    = c_v;
  assign predicted_id_o = c_pred_q;
  assign kept_count_o   = c_kept_q;

  // A real prediction is always a valid class id.
  a_pred_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_v && (c_pred_q != PredictedNone) |->
      (c_pred_q >= IdW'(1)) && (c_pred_q <= IdW'(CLASS_COUNT)))
    else $error("prediction outside class range");

  // Too few neighbors always gives the no-prediction code.
  a_short_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v && b_short_q && c_ready |=> c_v && (c_pred_q == PredictedNone))
    else $error("short list produced a prediction");

endmodule

/* hw/rtl/knn_majority_vote_classifier.sv */
// Top level of the nearest-neighbor majority vote classifier.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: sample_distance[31:0], sample_label[35:32]; tlast: last_sample
//  m_axis    out        tdata: predicted_id[4:0] (signed), kept_count[8:5]
//  cfg       in         index 0 filter_mode, 1 distance_limit, 2 available_mask
//
// One sample request is taken every cycle unless a last sample waits for the vote pipeline;
// the neighbor list updates with a single compare-and-insert per cycle over all slots in parallel.
// A query's result passes the sample register, label snapshot, tally and result registers.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds only the vote pipeline; samples keep flowing until
// another last sample finds the vote pipeline full.
module knn_majority_vote_classifier import knnmv_pkg::*; #(
  parameter int NEIGHBOURS  = 7,
  parameter int CLASS_COUNT = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // sample_distance, sample_label
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // predicted_id, kept_count
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(NEIGHBOURS + 2);

  logic [ModeW-1:0]  mode_q;
  logic [DistW-1:0]  limit_q;
  logic [MaskW-1:0]  mask_q;

  logic              smp_valid, smp_ready, step;
  sample_t           sample;
  logic              vote_ready;
  logic [LabelW-1:0] labels [NEIGHBOURS];
  logic [CntW-1:0]   count;
  logic [IdW-1:0]    predicted_id;
  logic [KeptW-1:0]  kept_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeBasic;
      limit_q <= DistLimitReset;
      mask_q  <= AvailMaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFilterMode: mode_q  <= cfg_data_i[ModeW-1:0];
        CfgDistLimit:  limit_q <= cfg_data_i[DistW-1:0];
        CfgAvailMask:  mask_q  <= cfg_data_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  knnmv_ingress #(
    .CLASS_COUNT (CLASS_COUNT)
  ) u_ingress (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_dist_i   (s_axis_tdata[DistW-1:0]),
    .in_label_i  (s_axis_tdata[DistW+LabelW-1:DistW]),
    .in_last_i   (s_axis_tlast),
    .mode_i      (mode_q),
    .limit_i     (limit_q),
    .mask_i      (mask_q),
    .out_valid_o (smp_valid),
    .out_ready_i (smp_ready),
    .sample_o    (sample)
  );

  // A last sample needs room in the vote pipeline; others always go through.
  assign smp_ready = !sample.last || vote_ready;
  assign step      = smp_valid && smp_ready;

  knnmv_list #(
    .NEIGHBOURS (NEIGHBOURS)
  ) u_list (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample),
    .labels_o (labels),
    .count_o  (count)
  );

  knnmv_vote #(
    .NEIGHBOURS  (NEIGHBOURS),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_vote (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (smp_valid && sample.last),
    .in_ready_o     (vote_ready),
    .labels_i       (labels),
    .count_i        (count),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .predicted_id_o (predicted_id),
    .kept_count_o   (kept_count)
  );

  assign m_axis_tdata = {{(OutDataW - IdW - KeptW){1'b0}}, kept_count, predicted_id};

endmodule
